@@ sv/corner_average_grid_upsampler_macros.svh @@
// Assertion macros used by the module that checks itself.
`ifndef CORNER_AVERAGE_GRID_UPSAMPLER_MACROS_SVH
`define CORNER_AVERAGE_GRID_UPSAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAGU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAGU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cagu_pkg.sv @@
package cagu_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int DIM_W        = 11;
  localparam int REG_W        = 11;
  localparam int VAL_W        = SAMPLE_BITS + 2;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
  } dims_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] up;
    logic [SAMPLE_BITS-1:0] up_left;
    logic [COL_W-1:0]       col;
    logic [ROW_W-1:0]       row;
    logic                   last_col;
    logic                   last_row;
  } item_t;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_RIGHT,
    PH_BOTTOM,
    PH_CORNER
  } phase_t;

endpackage

@@ sv/cagu_front.sv @@
module cagu_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cagu_pkg::dims_t                  dims,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cagu_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                             item_valid,
  output cagu_pkg::item_t                  item,
  input  logic                             item_ready
);
  import cagu_pkg::*;

  logic [COL_W-1:0]       col_count_r, col_count_nxt, col, col_prev;
  logic [ROW_W-1:0]       row_count_r, row_count_nxt, row;
  logic                   last_col, last_row, acc;
  logic [SAMPLE_BITS-1:0] left_r, left_nxt;

  logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] up_r, up_left_r;
  logic                   wr_en;
  logic [COL_W-1:0]       wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;

  logic                   pend_valid_r, pend_valid_nxt;
  logic [COL_W-1:0]       pend_addr_r;
  logic [SAMPLE_BITS-1:0] pend_data_r;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r, s1_left_r;
  logic [COL_W-1:0]       s1_col_r;
  logic [ROW_W-1:0]       s1_row_r;
  logic                   s1_last_col_r, s1_last_row_r;

  assign in_ready = !s1_valid_r || item_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    col      = (col_count_r > dims.col_last) ? dims.col_last : col_count_r;
    row      = (row_count_r > dims.row_last) ? dims.row_last : row_count_r;
    col_prev = col - COL_W'(1);
    last_col = (col == dims.col_last);
    last_row = (row == dims.row_last);

    col_count_nxt  = col_count_r;
    row_count_nxt  = row_count_r;
    left_nxt       = left_r;
    pend_valid_nxt = acc && last_col;
    s1_valid_nxt   = acc || (s1_valid_r && !item_ready);
    if (acc) begin
      left_nxt = in_sample;
      if (last_col) begin
        col_count_nxt = '0;
        row_count_nxt = last_row ? '0 : row + ROW_W'(1);
      end else begin
        col_count_nxt = col + COL_W'(1);
        row_count_nxt = row;
      end
    end

    // The closing entry of a row is written in the following cycle, when the port is free.
    if (acc && (col != '0)) begin
      wr_en   = 1'b1;
      wr_addr = col_prev;
      wr_data = left_r;
    end else begin
      wr_en   = pend_valid_r;
      wr_addr = pend_addr_r;
      wr_data = pend_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r  <= '0;
      row_count_r  <= '0;
      left_r       <= '0;
      pend_valid_r <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else begin
      col_count_r  <= col_count_nxt;
      row_count_r  <= row_count_nxt;
      left_r       <= left_nxt;
      pend_valid_r <= pend_valid_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_addr_r   <= col;
      pend_data_r   <= in_sample;
      s1_sample_r   <= in_sample;
      s1_left_r     <= left_r;
      s1_col_r      <= col;
      s1_row_r      <= row;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc) begin
      up_r      <= (pend_valid_r && (pend_addr_r == col)) ? pend_data_r : mem[col];
      up_left_r <= (pend_valid_r && (pend_addr_r == col_prev)) ? pend_data_r : mem[col_prev];
    end
  end

  assign item_valid = s1_valid_r;

  always_comb begin
    item.sample   = s1_sample_r;
    item.left     = s1_left_r;
    item.up       = up_r;
    item.up_left  = up_left_r;
    item.col      = s1_col_r;
    item.row      = s1_row_r;
    item.last_col = s1_last_col_r;
    item.last_row = s1_last_row_r;
  end

endmodule

@@ sv/cagu_queue.sv @@
module cagu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  cagu_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output cagu_pkg::item_t pop_item
);
  import cagu_pkg::*;

  item_t             slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/cagu_back.sv @@
module cagu_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cagu_pkg::dims_t            dims,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  cagu_pkg::item_t            item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cagu_pkg::VAL_W-1:0] out_vertex_value,
  output logic [cagu_pkg::DIM_W-1:0] out_row,
  output logic [cagu_pkg::DIM_W-1:0] out_col,
  output logic                       out_last_of_input,
  output logic                       out_frame_done
);
  import cagu_pkg::*;

  phase_t            phase_r, phase_nxt, phase_after;
  logic              load, is_last, r_nz, c_nz;
  logic [VAL_W-1:0]  op_a, op_b, op_c, sum, value;
  logic [1:0]        shift;
  logic [DIM_W-1:0]  width_full, height_full, row_o, col_o;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  value_r;
  logic [DIM_W-1:0]  row_r, col_r;
  logic              last_r, done_r;

  assign load       = item_valid && (!out_valid_r || out_ready);
  assign item_ready = load && is_last;
  assign r_nz       = (item.row != '0);
  assign c_nz       = (item.col != '0);
  assign width_full  = DIM_W'(dims.col_last) + DIM_W'(1);
  assign height_full = DIM_W'(dims.row_last) + DIM_W'(1);

  always_comb begin
    op_a        = '0;
    op_b        = '0;
    op_c        = '0;
    shift       = 2'd2;
    row_o       = DIM_W'(item.row);
    col_o       = DIM_W'(item.col);
    is_last     = 1'b1;
    phase_after = PH_BASE;
    case (phase_r)
      PH_BASE: begin
        op_a = r_nz ? VAL_W'(item.up) : '0;
        op_b = c_nz ? VAL_W'(item.left) : '0;
        op_c = (r_nz && c_nz) ? VAL_W'(item.up_left) : '0;
        shift = (r_nz && c_nz) ? 2'd0 : ((r_nz || c_nz) ? 2'd1 : 2'd2);
        is_last = !item.last_col && !item.last_row;
        phase_after = item.last_col ? PH_RIGHT : (item.last_row ? PH_BOTTOM : PH_BASE);
      end
      PH_RIGHT: begin
        op_a = r_nz ? VAL_W'(item.up) : '0;
        shift = r_nz ? 2'd1 : 2'd2;
        col_o = width_full;
        is_last = !item.last_row;
        phase_after = item.last_row ? PH_BOTTOM : PH_BASE;
      end
      PH_BOTTOM: begin
        op_b = c_nz ? VAL_W'(item.left) : '0;
        shift = c_nz ? 2'd1 : 2'd2;
        row_o = height_full;
        is_last = !item.last_col;
        phase_after = item.last_col ? PH_CORNER : PH_BASE;
      end
      PH_CORNER: begin
        row_o = height_full;
        col_o = width_full;
      end
      default: begin
      end
    endcase
    sum           = VAL_W'(item.sample) + op_a + op_b + op_c;
    value         = sum << shift;
    phase_nxt     = load ? phase_after : phase_r;
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BASE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value;
      row_r   <= row_o;
      col_r   <= col_o;
      last_r  <= is_last;
      done_r  <= (phase_r == PH_CORNER);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex_value  = value_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_last_of_input = last_r;
  assign out_frame_done    = done_r;

endmodule

@@ sv/corner_average_grid_upsampler.sv @@
// Turns a raster-order grid of samples into the grid of vertices one larger in each
// direction, each vertex the mean of the cells touching it with two extra fraction bits.
// An input transaction is taken every cycle while the queue has room and produces one vertex,
// two on the last column or last row, and four on the bottom-right sample; the single result
// port delivers one vertex per cycle while out_ready is high, so samples that yield several
// vertices can fill the queue and hold back the input. A sample is registered in the front
// stage, the queue and the output register before its vertices appear. The previous row sits
// in a 1024-entry memory with one write and two read ports; it needs no clearing after reset.
`include "corner_average_grid_upsampler_macros.svh"

module corner_average_grid_upsampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cagu_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cagu_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cagu_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cagu_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cagu_pkg::VAL_W-1:0]      out_vertex_value,
  output logic [cagu_pkg::DIM_W-1:0]      out_row,
  output logic [cagu_pkg::DIM_W-1:0]      out_col,
  output logic                            out_last_of_input,
  output logic                            out_frame_done
);
  import cagu_pkg::*;

  logic [REG_W-1:0] grid_width_r, grid_width_nxt, grid_height_r, grid_height_nxt;
  logic             cfg_write;
  reg_index_t       cfg_sel;
  dims_t            dims;
  logic             f_valid, f_ready, q_valid, q_ready;
  item_t            f_item, q_item;
  logic [DIM_W-1:0] width_full, height_full;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = reg_index_t'(paddr[2]);

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    prdata          = '0;
    case (cfg_sel)
      REG_GRID_WIDTH: begin
        prdata = APB_DATA_W'(grid_width_r);
        if (cfg_write) begin
          grid_width_nxt = pwdata[REG_W-1:0];
        end
      end
      REG_GRID_HEIGHT: begin
        prdata = APB_DATA_W'(grid_height_r);
        if (cfg_write) begin
          grid_height_nxt = pwdata[REG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= REG_W'(1024);
      grid_height_r <= REG_W'(1024);
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // Zero counts as one, larger values saturate to the storage limit.
  always_comb begin
    if (grid_width_r == '0) begin
      dims.col_last = '0;
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      dims.col_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      dims.col_last = COL_W'(grid_width_r - REG_W'(1));
    end
    if (grid_height_r == '0) begin
      dims.row_last = '0;
    end else if (32'(grid_height_r) > HEIGHT_LIMIT) begin
      dims.row_last = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      dims.row_last = ROW_W'(grid_height_r - REG_W'(1));
    end
  end

  cagu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  cagu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  cagu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .dims              (dims),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item              (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_value  (out_vertex_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_input (out_last_of_input),
    .out_frame_done    (out_frame_done)
  );

  assign width_full  = DIM_W'(dims.col_last) + DIM_W'(1);
  assign height_full = DIM_W'(dims.row_last) + DIM_W'(1);

  `CAGU_ASSERT_SAME(a_done_is_last, clk, rst_n, out_valid && out_frame_done, out_last_of_input, "frame end is not the last vertex of its sample")
  `CAGU_ASSERT_SAME(a_done_corner, clk, rst_n, out_valid && out_frame_done, (out_row == height_full) && (out_col == width_full), "frame end is not the bottom-right vertex")
  `CAGU_ASSERT_NEXT(a_frame_restart, clk, rst_n, out_valid && out_ready && out_frame_done, !out_valid || ((out_row == '0) && (out_col == '0)), "new frame does not start at the origin")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import cagu_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_SAMPLES  = 80;
  localparam int DIRECTED_STEPS = 23;
  localparam int WIDE_SAMPLES   = 41;
  localparam int TALL_SAMPLES   = 24;
  localparam int HOLD_SAMPLES   = 30;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
    logic             done;
  } vertex_t;

  typedef enum logic {
    ACT_SAMPLE,
    ACT_WRITE
  } action_t;

  typedef struct packed {
    action_t               act;
    reg_index_t            idx;
    logic [APB_DATA_W-1:0] data;
    logic                  typed;
    vertex_t               first;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [VAL_W-1:0]       out_vertex_value;
  logic [DIM_W-1:0]       out_row;
  logic [DIM_W-1:0]       out_col;
  logic                   out_last_of_input;
  logic                   out_frame_done;

  vertex_t                pending_vertices[$];
  logic [SAMPLE_BITS-1:0] pred_prev_row [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] pred_left = '0;
  int unsigned            pred_row = 0;
  int unsigned            pred_col = 0;
  logic [REG_W-1:0]       pred_width = REG_W'(MAX_WIDTH);
  logic [REG_W-1:0]       pred_height = REG_W'(HEIGHT_LIMIT);

  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  logic                   hold_req = 1'b0;
  int unsigned            samples_sent = 0;
  int unsigned            vertices_seen = 0;
  int unsigned            frames_seen = 0;
  int unsigned            mismatches = 0;

  step_t plan [DIRECTED_STEPS] = '{
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_FFFF, 1'b1, '{18'h3FFFC, 11'd0, 11'd0, 1'b1, 1'b0}},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_0000, 1'b1, '{18'h1FFFE, 11'd0, 11'd1, 1'b1, 1'b0}},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_0001, 1'b1, '{18'h00002, 11'd0, 11'd2, 1'b1, 1'b0}},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_8000, 1'b1, '{18'h10002, 11'd0, 11'd3, 1'b1, 1'b0}},
    '{ACT_WRITE,  REG_GRID_WIDTH,  32'hFFFF_F803, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_HEIGHT, 32'h0000_0002, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_7FFF, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_1234, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_FFFF, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_0000, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_WIDTH,  32'h0000_0000, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_HEIGHT, 32'hABCD_E800, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_FFFF, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_0000, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_WIDTH,  32'h0000_0002, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_HEIGHT, 32'h0000_07FF, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_00FF, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_FF00, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_5555, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_AAAA, 1'b0, '0},
    '{ACT_WRITE,  REG_GRID_HEIGHT, 32'h0000_0001, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_0F0F, 1'b0, '0},
    '{ACT_SAMPLE, REG_GRID_WIDTH, 32'h0000_F0F0, 1'b0, '0}
  };

  corner_average_grid_upsampler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex_value  (out_vertex_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_input (out_last_of_input),
    .out_frame_done    (out_frame_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic vertex_t make_vertex(input int unsigned sum, input int unsigned cnt,
                                          input int unsigned row, input int unsigned col,
                                          input logic done);
    vertex_t     v;
    int unsigned scaled;
    scaled = (cnt == 1) ? (sum << 2) : (cnt == 2) ? (sum << 1) : sum;
    v.value = scaled[VAL_W-1:0];
    v.row   = row[DIM_W-1:0];
    v.col   = col[DIM_W-1:0];
    v.last  = 1'b0;
    v.done  = done;
    return v;
  endfunction

  // Each sample yields its own vertex, then the row-closing vertex on the last column,
  // then the bottom-row vertices on the last row.
  function automatic void predict_vertices(input logic [SAMPLE_BITS-1:0] s,
                                           ref vertex_t res[$]);
    int unsigned w, h, c, r, sum, cnt, up, up_left;
    bit          last_col, last_row;
    res.delete();
    w = (pred_width == 0) ? 1 : (pred_width > MAX_WIDTH) ? MAX_WIDTH : pred_width;
    h = (pred_height == 0) ? 1 : (pred_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : pred_height;
    c = (pred_col >= w) ? w - 1 : pred_col;
    r = (pred_row >= h) ? h - 1 : pred_row;
    up = pred_prev_row[c];
    up_left = (c > 0) ? pred_prev_row[c-1] : 0;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    sum = s;
    cnt = 1;
    if (r > 0) begin
      sum += up;
      cnt++;
    end
    if (c > 0) begin
      sum += pred_left;
      cnt++;
      if (r > 0) begin
        sum += up_left;
        cnt++;
      end
    end
    res.push_back(make_vertex(sum, cnt, r, c, 1'b0));
    if (last_col) begin
      res.push_back(make_vertex(s + ((r > 0) ? up : 0), (r > 0) ? 2 : 1, r, w, 1'b0));
    end
    if (last_row) begin
      res.push_back(make_vertex(s + ((c > 0) ? pred_left : 0), (c > 0) ? 2 : 1, h, c, 1'b0));
      if (last_col) begin
        res.push_back(make_vertex(s, 1, h, w, 1'b1));
      end
    end
    res[res.size()-1].last = 1'b1;
    if (c > 0) begin
      pred_prev_row[c-1] = pred_left;
    end
    if (last_col) begin
      pred_prev_row[c] = s;
    end
    pred_left = s;
    if (last_col) begin
      pred_col = 0;
      pred_row = last_row ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
      pred_row = r;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return SAMPLE_BITS'($urandom());
      end
    endcase
  endfunction

  function automatic int unsigned pick_dim(input int unsigned common_hi,
                                           input int unsigned rare_hi);
    case ($urandom_range(0, 9))
      0: begin
        return 0;
      end
      1: begin
        return $urandom_range(1, rare_hi);
      end
      default: begin
        return $urandom_range(1, common_hi);
      end
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic typed,
                             input vertex_t first);
    vertex_t res[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predict_vertices(s, res);
    if (typed) begin
      res[0] = first;
    end
    foreach (res[i]) pending_vertices.push_back(res[i]);
    samples_sent++;
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] data);
    quiesce();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_GRID_WIDTH) begin
      pred_width = data[REG_W-1:0];
    end else begin
      pred_height = data[REG_W-1:0];
    end
  endtask

  // Some frames stop early so that the next size change lands in the middle of a frame.
  task automatic run_frames(input int unsigned count);
    int unsigned target, w, h, n;
    target = samples_sent + count;
    while (samples_sent < target) begin
      w = pick_dim(6, 40);
      h = pick_dim(4, 8);
      write_reg(REG_GRID_WIDTH, ($urandom() & ~32'h7FF) | w);
      write_reg(REG_GRID_HEIGHT, ($urandom() & ~32'h7FF) | h);
      n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, n);
      end
      repeat (n) push_sample(pick_sample(), 1'b0, '0);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    vertex_t got;
    vertex_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_vertex_value, out_row, out_col, out_last_of_input, out_frame_done};
      vertices_seen++;
      if (got.done) begin
        frames_seen++;
      end
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected vertex: value %0d row %0d col %0d last %b done %b",
                   got.value, got.row, got.col, got.last, got.done);
        end
      end else begin
        want = pending_vertices.pop_front();
        if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
            got.last !== want.last || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Vertex mismatch: expected value %0d row %0d col %0d last %b done %b",
                     want.value, want.row, want.col, want.last, want.done);
            $display("                 actual   value %0d row %0d col %0d last %b done %b",
                     got.value, got.row, got.col, got.last, got.done);
          end
        end
      end
    end
  end

  initial begin
    foreach (pred_prev_row[i]) pred_prev_row[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_stall_pct = 79;
    foreach (plan[i]) begin
      if (plan[i].act == ACT_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_sample(plan[i].data[SAMPLE_BITS-1:0], plan[i].typed, plan[i].first);
      end
    end

    // A single wide row fills every row entry that the random frames can reach.
    write_reg(REG_GRID_WIDTH, 32'h0000_07FF);
    write_reg(REG_GRID_HEIGHT, 32'h0000_0001);
    repeat (WIDE_SAMPLES) push_sample(pick_sample(), 1'b0, '0);
    write_reg(REG_GRID_WIDTH, 32'h0000_0001);
    write_reg(REG_GRID_HEIGHT, 32'hFFFF_FFFF);
    repeat (TALL_SAMPLES) push_sample(pick_sample(), 1'b0, '0);

    run_frames(PHASE_SAMPLES);
    send_idle_pct = 79;
    recv_stall_pct = 36;
    run_frames(PHASE_SAMPLES);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_GRID_WIDTH, 32'h0000_0005);
    write_reg(REG_GRID_HEIGHT, 32'h0000_0006);
    hold_req = 1'b1;
    repeat (HOLD_SAMPLES) push_sample(pick_sample(), 1'b0, '0);
    run_frames(PHASE_SAMPLES);
    quiesce();

    $display("Checked %0d vertices from %0d samples, %0d complete frames.",
             vertices_seen, samples_sent, frames_seen);
    $display("Covered reset sizes, zero and oversized sizes, mid-frame resizing and stalls.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("Timed out with %0d vertices still expected.", pending_vertices.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
